FILE: hw/rtl/arfs_pkg.sv
// Package with the widths, register indexes, defaults, request codes and entry type of the rate fallback selector.
`default_nettype none
package arfs_pkg;

   localparam int NEIGHBORS  = 16;
   localparam int NB_W       = $clog2(NEIGHBORS);
   localparam int MAX_RATES  = 32;
   localparam int RATE_W     = 5;
   localparam int COUNT_W    = 6;
   localparam int CNT_W      = 16;
   localparam int RETRY_W    = 4;
   localparam int TRIES0_W   = 3;
   localparam int TRIES_W    = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPUP   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0]    STEPUP_RESET   = CNT_W'(10);
   localparam logic [TRIES0_W-1:0] TRIES_PRIMARY  = TRIES0_W'(4);
   localparam logic [TRIES_W-1:0]  TRIES_FALLBACK = TRIES_W'(2);

   localparam logic REQ_RATE     = 1'b0;
   localparam logic REQ_FEEDBACK = 1'b1;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [CNT_W-1:0]  count;
      logic [CNT_W-1:0]  thresh;
      logic              went_up;
   } entry_type;

endpackage
`default_nettype wire

FILE: hw/rtl/auto_rate_fallback_selector_core.sv
// Top level of the auto rate fallback selector with its per-neighbour state table.
//
//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_ready  | rate request or transmit feedback
//  rsp     | out       | rsp_valid / rsp_ready  | retry chain and updated rate index
//  csr     | in        | csr_valid / csr_ready  | register index and write data
//
// Each word passes through the input register and then the result register; a new word is
// taken in every cycle while the result register is empty or its result is being taken.
// The neighbour entry is read, and rewritten where needed, in the cycle the word leaves the input register.
// Reset clears all entry valid bits and loads the register defaults.
// A stalled result holds the input register, and the request side stalls once both are full.
`default_nettype none
module auto_rate_fallback_selector_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_type,
   input  wire logic [arfs_pkg::NB_W-1:0]        req_neighbor_id,
   input  wire logic                             req_is_group,
   input  wire logic [arfs_pkg::COUNT_W-1:0]     req_rate_count,
   input  wire logic                             req_tx_failed,
   input  wire logic                             req_used_alt_rate,
   input  wire logic [arfs_pkg::RETRY_W-1:0]     req_retries,
   input  wire logic [arfs_pkg::RATE_W-1:0]      req_used_rate_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [arfs_pkg::RATE_W-1:0]           rsp_rate0_index,
   output logic [arfs_pkg::RATE_W-1:0]           rsp_rate1_index,
   output logic [arfs_pkg::RATE_W-1:0]           rsp_rate2_index,
   output logic [arfs_pkg::RATE_W-1:0]           rsp_rate3_index,
   output logic [arfs_pkg::TRIES0_W-1:0]         rsp_tries0,
   output logic [arfs_pkg::TRIES_W-1:0]          rsp_tries1,
   output logic [arfs_pkg::TRIES_W-1:0]          rsp_tries2,
   output logic [arfs_pkg::TRIES_W-1:0]          rsp_tries3,
   output logic                                  rsp_use_basic_default,
   output logic [arfs_pkg::RATE_W-1:0]           rsp_index_after,
   output logic                                  rsp_feedback_applied,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [arfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [arfs_pkg::CNT_W-1:0]       csr_data
);
   import arfs_pkg::*;

   logic               in_valid_ff;
   logic               in_type_ff;
   logic [NB_W-1:0]    in_nb_ff;
   logic               in_group_ff;
   logic [COUNT_W-1:0] in_count_ff;
   logic               in_failed_ff;
   logic               in_alt_ff;
   logic [RETRY_W-1:0] in_retries_ff;
   logic [RATE_W-1:0]  in_used_ff;

   logic [CNT_W-1:0]   cfg_stepup_ff;
   logic               cfg_adaptive_ff;

   logic [NEIGHBORS-1:0] entry_valid_ff;
   entry_type            entry_ff [NEIGHBORS];

   logic                rsp_valid_ff;
   logic [RATE_W-1:0]   rsp_rate0_ff, rsp_rate1_ff, rsp_rate2_ff, rsp_rate3_ff;
   logic [TRIES0_W-1:0] rsp_tries0_ff;
   logic [TRIES_W-1:0]  rsp_tries1_ff, rsp_tries2_ff, rsp_tries3_ff;
   logic                rsp_basic_ff;
   logic [RATE_W-1:0]   rsp_after_ff;
   logic                rsp_applied_ff;

   logic [RATE_W-1:0]   rsp_rate0_in, rsp_rate1_in, rsp_rate2_in, rsp_rate3_in;
   logic [TRIES0_W-1:0] rsp_tries0_in;
   logic [TRIES_W-1:0]  rsp_tries1_in, rsp_tries2_in, rsp_tries3_in;
   logic                rsp_basic_in;
   logic [RATE_W-1:0]   rsp_after_in;
   logic                rsp_applied_in;

   logic              advance;
   logic              rd_valid;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic              wr_en;
   logic              valid_after;
   logic [RATE_W-1:0] top;
   logic [RATE_W-1:0] ndx;
   logic [2:0]        down;
   logic [CNT_W-1:0]  thr_ok;
   logic [CNT_W-1:0]  cnt_ok;
   logic [RATE_W:0]   rate_plus;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rd_valid  = entry_valid_ff[in_nb_ff];
   assign rd_entry  = entry_ff[in_nb_ff];

   always_comb begin
      if (in_count_ff > COUNT_W'(MAX_RATES)) begin
         top = RATE_W'(MAX_RATES - 1);
      end else if (in_count_ff == '0) begin
         top = '0;
      end else begin
         top = RATE_W'(in_count_ff - 1'b1);
      end
   end

   always_comb begin
      wr_entry       = rd_entry;
      wr_en          = 1'b0;
      valid_after    = rd_valid;
      ndx            = rd_valid ? rd_entry.rate : top;
      down           = '0;
      thr_ok         = rd_entry.thresh;
      cnt_ok         = rd_entry.count;
      rate_plus      = {1'b0, rd_entry.rate} + 1'b1;
      rsp_rate0_in   = '0;
      rsp_rate1_in   = '0;
      rsp_rate2_in   = '0;
      rsp_rate3_in   = '0;
      rsp_tries0_in  = '0;
      rsp_tries1_in  = '0;
      rsp_tries2_in  = '0;
      rsp_tries3_in  = '0;
      rsp_basic_in   = 1'b0;
      rsp_applied_in = 1'b0;
      if (in_type_ff == REQ_RATE) begin
         if (in_group_ff) begin
            rsp_basic_in = (in_count_ff == '0);
         end else begin
            if (!rd_valid) begin
               wr_en            = 1'b1;
               valid_after      = 1'b1;
               wr_entry.rate    = top;
               wr_entry.count   = '0;
               wr_entry.thresh  = cfg_stepup_ff;
               wr_entry.went_up = 1'b0;
            end
            rsp_rate0_in  = ndx;
            rsp_tries0_in = TRIES_PRIMARY;
            if (ndx >= RATE_W'(1)) begin
               rsp_rate1_in  = ndx - RATE_W'(1);
               rsp_tries1_in = TRIES_FALLBACK;
            end
            if (ndx >= RATE_W'(2)) begin
               rsp_rate2_in  = ndx - RATE_W'(2);
               rsp_tries2_in = TRIES_FALLBACK;
            end
            if (ndx >= RATE_W'(3)) begin
               rsp_rate3_in  = ndx - RATE_W'(3);
               rsp_tries3_in = TRIES_FALLBACK;
            end
         end
      end else if (rd_valid && rd_entry.rate == in_used_ff) begin
         wr_en          = 1'b1;
         rsp_applied_in = 1'b1;
         if (in_alt_ff || in_failed_ff) begin
            down = in_retries_ff[RETRY_W-1:1];
            if (down != '0) begin
               down = down - 1'b1;
            end
            wr_entry.rate = (rd_entry.rate > RATE_W'(down)) ?
                            rd_entry.rate - RATE_W'(down) : '0;
            if (rd_entry.went_up && cfg_adaptive_ff) begin
               wr_entry.thresh  = rd_entry.thresh[CNT_W-1] ? '1 :
                                  {rd_entry.thresh[CNT_W-2:0], 1'b0};
               wr_entry.went_up = 1'b0;
            end else begin
               wr_entry.thresh = cfg_stepup_ff;
            end
            wr_entry.count = '0;
         end else begin
            thr_ok = rd_entry.went_up ? cfg_stepup_ff : rd_entry.thresh;
            if (in_retries_ff == '0) begin
               cnt_ok = (rd_entry.count != '1) ? rd_entry.count + 1'b1 : rd_entry.count;
            end else begin
               cnt_ok = '0;
            end
            wr_entry.thresh  = thr_ok;
            wr_entry.count   = cnt_ok;
            wr_entry.went_up = 1'b0;
            if (cnt_ok > thr_ok && rd_entry.rate != top) begin
               wr_entry.rate    = (rate_plus < {1'b0, top}) ? rate_plus[RATE_W-1:0] : top;
               wr_entry.count   = '0;
               wr_entry.went_up = 1'b1;
            end
         end
      end
      rsp_after_in = valid_after ? wr_entry.rate : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         entry_valid_ff  <= '0;
         cfg_stepup_ff   <= STEPUP_RESET;
         cfg_adaptive_ff <= 1'b1;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && valid_after) begin
            entry_valid_ff[in_nb_ff] <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_STEPUP:   cfg_stepup_ff   <= csr_data;
               CSR_ADAPTIVE: cfg_adaptive_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff    <= req_type;
         in_nb_ff      <= req_neighbor_id;
         in_group_ff   <= req_is_group;
         in_count_ff   <= req_rate_count;
         in_failed_ff  <= req_tx_failed;
         in_alt_ff     <= req_used_alt_rate;
         in_retries_ff <= req_retries;
         in_used_ff    <= req_used_rate_index;
      end
      if (advance && wr_en) begin
         entry_ff[in_nb_ff] <= wr_entry;
      end
      if (advance) begin
         rsp_rate0_ff   <= rsp_rate0_in;
         rsp_rate1_ff   <= rsp_rate1_in;
         rsp_rate2_ff   <= rsp_rate2_in;
         rsp_rate3_ff   <= rsp_rate3_in;
         rsp_tries0_ff  <= rsp_tries0_in;
         rsp_tries1_ff  <= rsp_tries1_in;
         rsp_tries2_ff  <= rsp_tries2_in;
         rsp_tries3_ff  <= rsp_tries3_in;
         rsp_basic_ff   <= rsp_basic_in;
         rsp_after_ff   <= rsp_after_in;
         rsp_applied_ff <= rsp_applied_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rate0_index       = rsp_rate0_ff;
   assign rsp_rate1_index       = rsp_rate1_ff;
   assign rsp_rate2_index       = rsp_rate2_ff;
   assign rsp_rate3_index       = rsp_rate3_ff;
   assign rsp_tries0            = rsp_tries0_ff;
   assign rsp_tries1            = rsp_tries1_ff;
   assign rsp_tries2            = rsp_tries2_ff;
   assign rsp_tries3            = rsp_tries3_ff;
   assign rsp_use_basic_default = rsp_basic_ff;
   assign rsp_index_after       = rsp_after_ff;
   assign rsp_feedback_applied  = rsp_applied_ff;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("Request side stalled while a stage was free.");

   a_unicast_makes_valid: assert property (@(posedge clock) disable iff (reset)
      (advance && in_type_ff == REQ_RATE && !in_group_ff) |=> entry_valid_ff[$past(in_nb_ff)])
      else $error("Unicast request left its neighbour entry invalid.");

   a_primary_is_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tries0_ff == TRIES_PRIMARY) |-> (rsp_rate0_ff == rsp_after_ff))
      else $error("Primary rate differs from the neighbour's current rate.");
`endif

endmodule
`default_nettype wire
